### src/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on clk, switched off while rst is high.
`define CSIM_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Concurrent check on clk that must also hold across reset.
`define CSIM_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### src/csim_pkg.sv
`default_nettype none

package csim_pkg;

  localparam int ELEM_W  = 16;
  localparam int PROD_W  = 2 * ELEM_W;
  localparam int ACC_W   = 40;
  localparam int OUT_W   = 16;

  localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};
  localparam logic signed [OUT_W-1:0] Q14_ONE = OUT_W'(16384);

  // Back end: 40x40 products built from four 20x20 partial products each.
  localparam int HALF_W    = ACC_W / 2;
  localparam int WIDE_PROD = 2 * ACC_W;
  localparam int MUL_STEPS = 8;
  localparam int STEP_W    = $clog2(MUL_STEPS + 1);

  // Quotient search: one bit per pass, bits up to and including 2^14.
  localparam int QBITS       = 15;
  localparam int BIT_W       = $clog2(QBITS);
  localparam int SEARCH_SHIFT = 2 * (QBITS - 1);
  localparam int RHS_SHIFT   = 28;
  localparam int WIDE_W      = 110;

  // Queue between front and back; depth must be a power of two.
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  typedef struct packed {
    logic signed [ACC_W-1:0] dot;
    logic signed [ACC_W-1:0] norm_a;
    logic signed [ACC_W-1:0] norm_b;
  } norms_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_MUL,
    BK_INIT,
    BK_SUM,
    BK_TEST,
    BK_DONE
  } back_state_t;

endpackage

`default_nettype wire

### src/csim_ifs.sv
`default_nettype none

interface csim_pair_if;
  import csim_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [ELEM_W-1:0] a_element;
  logic signed [ELEM_W-1:0] b_element;
  logic                     last;

  modport source (output valid, output a_element, output b_element, output last,
                  input ready);
  modport sink (input valid, input a_element, input b_element, input last,
                output ready);
endinterface

interface csim_result_if;
  import csim_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [OUT_W-1:0] similarity;
  logic                    zero_norm;

  modport source (output valid, output similarity, output zero_norm, input ready);
  modport sink (input valid, input similarity, input zero_norm, output ready);
endinterface

`default_nettype wire

### src/csim_front.sv
`default_nettype none

module csim_front (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic signed [csim_pkg::ELEM_W-1:0] a_element,
  input  logic signed [csim_pkg::ELEM_W-1:0] b_element,
  input  logic                           last,
  output logic                           push,
  output csim_pkg::norms_t               push_data,
  input  logic                           push_ready
);
  import csim_pkg::*;

  function automatic logic signed [ACC_W-1:0] sat_acc(
    input logic signed [ACC_W-1:0]  acc,
    input logic signed [PROD_W-1:0] p
  );
    logic signed [ACC_W:0] s;
    s = (ACC_W+1)'(acc) + (ACC_W+1)'(p);
    if (s[ACC_W] != s[ACC_W-1]) begin
      sat_acc = s[ACC_W] ? ACC_MIN : ACC_MAX;
    end else begin
      sat_acc = s[ACC_W-1:0];
    end
  endfunction

  logic                     s1_valid;
  logic                     s1_last;
  logic signed [PROD_W-1:0] s1_ab;
  logic signed [PROD_W-1:0] s1_aa;
  logic signed [PROD_W-1:0] s1_bb;

  logic signed [ACC_W-1:0]  dot_acc;
  logic signed [ACC_W-1:0]  norm_a_acc;
  logic signed [ACC_W-1:0]  norm_b_acc;

  logic signed [ACC_W-1:0]  dot_next;
  logic signed [ACC_W-1:0]  norm_a_next;
  logic signed [ACC_W-1:0]  norm_b_next;
  logic                     advance;

  // A last beat in the product stage waits for room in the queue.
  assign in_ready = !(s1_valid && s1_last && !push_ready);
  assign advance  = s1_valid && in_ready;

  assign dot_next    = sat_acc(dot_acc, s1_ab);
  assign norm_a_next = sat_acc(norm_a_acc, s1_aa);
  assign norm_b_next = sat_acc(norm_b_acc, s1_bb);

  assign push             = advance && s1_last;
  assign push_data.dot    = dot_next;
  assign push_data.norm_a = norm_a_next;
  assign push_data.norm_b = norm_b_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_last <= last;
      s1_ab   <= PROD_W'(a_element) * PROD_W'(b_element);
      s1_aa   <= PROD_W'(a_element) * PROD_W'(a_element);
      s1_bb   <= PROD_W'(b_element) * PROD_W'(b_element);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dot_acc    <= '0;
      norm_a_acc <= '0;
      norm_b_acc <= '0;
    end else if (advance) begin
      if (s1_last) begin
        dot_acc    <= '0;
        norm_a_acc <= '0;
        norm_b_acc <= '0;
      end else begin
        dot_acc    <= dot_next;
        norm_a_acc <= norm_a_next;
        norm_b_acc <= norm_b_next;
      end
    end
  end

endmodule

`default_nettype wire

### src/csim_queue.sv
`default_nettype none

module csim_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  csim_pkg::norms_t push_data,
  output logic             push_ready,
  input  logic             pop,
  output logic             pop_valid,
  output csim_pkg::norms_t pop_data
);
  import csim_pkg::*;

  norms_t              entries [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr;
  logic [QUEUE_AW-1:0] rd_ptr;
  logic [QUEUE_AW:0]   count;

  assign push_ready = count != (QUEUE_AW+1)'(QUEUE_DEPTH);
  assign pop_valid  = count != '0;
  assign pop_data   = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

endmodule

`default_nettype wire

### src/csim_back.sv
`default_nettype none

module csim_back (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              job_valid,
  input  csim_pkg::norms_t                  job,
  output logic                              job_pop,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [csim_pkg::OUT_W-1:0] similarity,
  output logic                              zero_norm
);
  import csim_pkg::*;

  back_state_t state, state_next;

  logic                    dot_neg;
  logic                    res_zero;
  logic [ACC_W-1:0]        mag;
  logic [ACC_W-1:0]        norm_a;
  logic [ACC_W-1:0]        norm_b;
  logic [STEP_W-1:0]       step;
  logic [2*HALF_W-1:0]     pp;
  logic [1:0]              pp_shift;
  logic                    pp_sq;
  logic                    pp_valid;
  logic [WIDE_PROD-1:0]    prod_p;
  logic [WIDE_PROD-1:0]    prod_m;
  logic [WIDE_W-1:0]       sq_t;
  logic [WIDE_W-1:0]       sh_u;
  logic [WIDE_W-1:0]       pk;
  logic [WIDE_W-1:0]       rhs;
  logic [WIDE_W-1:0]       part;
  logic [QBITS-1:0]        quot;
  logic [BIT_W-1:0]        bit_cnt;

  logic                    job_zero;
  logic                    out_free;
  logic                    finish;
  logic [ACC_W-1:0]        mul_x;
  logic [ACC_W-1:0]        mul_y;
  logic [HALF_W-1:0]       x_half;
  logic [HALF_W-1:0]       y_half;
  logic [WIDE_PROD-1:0]    pp_ext;
  logic [WIDE_PROD-1:0]    pp_aligned;
  logic [WIDE_W-1:0]       cand;
  logic                    fit;
  logic [WIDE_W-1:0]       u_add;
  logic signed [OUT_W-1:0] sim_mag;
  logic signed [OUT_W-1:0] sim_val;

  // A norm that is zero or negative forces a zero result.
  assign job_zero = job.norm_a[ACC_W-1] || (job.norm_a == '0) ||
                    job.norm_b[ACC_W-1] || (job.norm_b == '0);
  assign out_free = !out_valid || out_ready;

  // Partial product select: step[2] picks the pair, step[1:0] the halves.
  assign mul_x  = step[2] ? mag : norm_a;
  assign mul_y  = step[2] ? mag : norm_b;
  assign x_half = step[0] ? mul_x[ACC_W-1:HALF_W] : mul_x[HALF_W-1:0];
  assign y_half = step[1] ? mul_y[ACC_W-1:HALF_W] : mul_y[HALF_W-1:0];

  assign pp_ext = WIDE_PROD'(pp);
  always_comb begin
    unique case (pp_shift)
      2'd0:    pp_aligned = pp_ext;
      2'd1:    pp_aligned = pp_ext << HALF_W;
      2'd2:    pp_aligned = pp_ext << (2 * HALF_W);
      default: pp_aligned = '0;
    endcase
  end

  // Candidate (q + 2^k)^2 * P = q^2*P + q*P*2^(k+1) + P*2^(2k).
  assign cand  = part + pk;
  assign fit   = cand <= rhs;
  assign u_add = fit ? (sh_u + (pk << 1)) : sh_u;

  assign sim_mag = quot[QBITS-1] ? Q14_ONE : OUT_W'(quot);
  assign sim_val = res_zero ? '0 : (dot_neg ? -sim_mag : sim_mag);

  always_comb begin
    state_next = state;
    unique case (state)
      BK_IDLE: begin
        if (job_valid) begin
          state_next = job_zero ? BK_DONE : BK_MUL;
        end
      end
      BK_MUL: begin
        if (step == STEP_W'(MUL_STEPS)) begin
          state_next = BK_INIT;
        end
      end
      BK_INIT: state_next = BK_SUM;
      BK_SUM:  state_next = BK_TEST;
      BK_TEST: begin
        if (bit_cnt == '0) begin
          state_next = BK_DONE;
        end else begin
          state_next = BK_SUM;
        end
      end
      BK_DONE: begin
        if (out_free) begin
          state_next = BK_IDLE;
        end
      end
      default: state_next = BK_IDLE;
    endcase
  end

  always_comb begin
    job_pop = (state == BK_IDLE) && job_valid;
    finish  = (state == BK_DONE) && out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (job_pop) begin
      dot_neg  <= job.dot[ACC_W-1];
      mag      <= job.dot[ACC_W-1] ? ACC_W'(-job.dot) : ACC_W'(job.dot);
      norm_a   <= ACC_W'(job.norm_a);
      norm_b   <= ACC_W'(job.norm_b);
      res_zero <= job_zero;
      step     <= '0;
      pp_valid <= 1'b0;
      prod_p   <= '0;
      prod_m   <= '0;
      quot     <= '0;
    end

    if (state == BK_MUL) begin
      if (step < STEP_W'(MUL_STEPS)) begin
        pp       <= x_half * y_half;
        pp_shift <= 2'(step[0]) + 2'(step[1]);
        pp_sq    <= step[2];
        pp_valid <= 1'b1;
      end else begin
        pp_valid <= 1'b0;
      end
      if (pp_valid) begin
        if (pp_sq) begin
          prod_m <= prod_m + pp_aligned;
        end else begin
          prod_p <= prod_p + pp_aligned;
        end
      end
      step <= step + 1'b1;
    end

    if (state == BK_INIT) begin
      pk      <= WIDE_W'({prod_p, {SEARCH_SHIFT{1'b0}}});
      rhs     <= WIDE_W'({prod_m, {RHS_SHIFT{1'b0}}});
      sq_t    <= '0;
      sh_u    <= '0;
      bit_cnt <= BIT_W'(QBITS - 1);
    end

    if (state == BK_SUM) begin
      part <= sq_t + sh_u;
    end

    if (state == BK_TEST) begin
      if (fit) begin
        sq_t <= cand;
      end
      sh_u    <= u_add >> 1;
      pk      <= pk >> 2;
      quot    <= {quot[QBITS-2:0], fit};
      bit_cnt <= bit_cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (finish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Hold the result beat until taken.
  always_ff @(posedge clk) begin
    if (finish) begin
      similarity <= sim_val;
      zero_norm  <= res_zero;
    end
  end

endmodule

`default_nettype wire

### src/cosine_similarity_unit.sv
// Throughput: one element pair per cycle on the input side, stalled only when a last
// beat meets a full result queue; the back end takes one job at a time, working
// through its 40-bit product steps and then the quotient search, one bit per pass.
// A result follows the beat marked last through the queue, the product steps and the search.
// Reset (rst, synchronous, active high) clears the accumulators, the queue and
// the back end; no clearing pass, the block takes pairs in the next cycle.
`default_nettype none

module cosine_similarity_unit (
  input  logic          clk,
  input  logic          rst,
  csim_pair_if.sink     pairs,
  csim_result_if.source results
);
  import csim_pkg::*;

  logic   push;
  logic   push_ready;
  logic   job_valid;
  logic   job_pop;
  norms_t push_data;
  norms_t job;

  csim_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (pairs.valid),
    .in_ready   (pairs.ready),
    .a_element  (pairs.a_element),
    .b_element  (pairs.b_element),
    .last       (pairs.last),
    .push       (push),
    .push_data  (push_data),
    .push_ready (push_ready)
  );

  csim_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_data  (push_data),
    .push_ready (push_ready),
    .pop        (job_pop),
    .pop_valid  (job_valid),
    .pop_data   (job)
  );

  csim_back u_back (
    .clk        (clk),
    .rst        (rst),
    .job_valid  (job_valid),
    .job        (job),
    .job_pop    (job_pop),
    .out_valid  (results.valid),
    .out_ready  (results.ready),
    .similarity (results.similarity),
    .zero_norm  (results.zero_norm)
  );

endmodule

`default_nettype wire

### src/csim_checker.sv
`default_nettype none
`include "assert_macros.svh"

module csim_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic signed [csim_pkg::OUT_W-1:0] similarity,
  input logic                              zero_norm
);
  import csim_pkg::*;

  `CSIM_ASSERT_ALWAYS(a_reset_drops_valid, rst |=> !out_valid, "result valid after reset")
  `CSIM_ASSERT(a_result_held, out_valid && !out_ready |=> out_valid && $stable(similarity) && $stable(zero_norm), "stalled result beat changed")
  `CSIM_ASSERT(a_zero_norm_value, out_valid && zero_norm |-> similarity == '0, "zero norm with nonzero similarity")
  `CSIM_ASSERT(a_similarity_range, out_valid |-> (similarity <= Q14_ONE) && (similarity >= -Q14_ONE), "similarity beyond plus or minus one")

endmodule

bind cosine_similarity_unit csim_checker u_csim_checker (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (results.valid),
  .out_ready  (results.ready),
  .similarity (results.similarity),
  .zero_norm  (results.zero_norm)
);

`default_nettype wire
